/* rtl/kpss_pkg.sv */
// Shared types and constants for the keypad setpoint position servo.
// Depends on nothing; every other file of the block imports it.
package kpss_pkg;

  localparam int unsigned OP_W        = 2;
  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned COUNT_W     = 8;
  localparam int unsigned DUTY_W      = 10;
  localparam int unsigned GAIN_W      = 12;
  localparam int unsigned DEADBAND_W  = 8;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 12;

  // Largest duty the outputs can carry.
  localparam int unsigned DUTY_LIMIT = 1023;

  // Entry of three decimal digits; a digit may be up to 15, so the angle
  // reaches 1665 at most.
  localparam int unsigned DIGIT_SLOTS = 3;
  localparam int unsigned DCOUNT_W    = 2;
  localparam int unsigned ANGLE_W     = 11;

  localparam logic [COUNT_W-1:0] TARGET_RESET = COUNT_W'(80);

  // Datapath widths: gain times error, times the duty span, and the
  // quotient stage that divides by a constant through a reciprocal.
  localparam int unsigned FRAC_W      = 8;
  localparam int unsigned MAG_W       = 20;
  localparam int unsigned PROD_W      = 30;
  localparam int unsigned NUM_W       = PROD_W - FRAC_W;
  localparam int unsigned DIV_W       = 10;
  localparam int unsigned RECIP_SHIFT = 30;
  localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [OP_W-1:0] {
    OP_DIGIT   = 2'd0,
    OP_ENTER   = 2'd1,
    OP_ENCODER = 2'd2,
    OP_TICK    = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    KIND_DIGIT   = 4'b0001,
    KIND_ENTER   = 4'b0010,
    KIND_ENCODER = 4'b0100,
    KIND_TICK    = 4'b1000
  } kind_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_GAIN     = 2'd0,
    CFG_DEADBAND = 2'd1,
    CFG_MIN_DUTY = 2'd2
  } cfg_index_e;

  typedef enum logic [STATUS_W-1:0] {
    ENTRY_NONE     = 2'd0,
    ENTRY_ACCEPTED = 2'd1,
    ENTRY_REJECTED = 2'd2
  } entry_status_e;

  typedef struct packed {
    kind_e               kind;
    logic [DIGIT_W-1:0]  digit;
    logic                cw;
  } queue_item_t;

  typedef struct packed {
    logic        valid;
    queue_item_t item;
  } queue_head_t;

  typedef struct packed {
    logic                   we;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
  } cfg_write_t;

endpackage

/* rtl/kpss_channels_if.sv */
// Valid/ready channel interfaces for the servo's event items and results.
// Depends on kpss_pkg for the field widths.
interface kpss_item_if import kpss_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [DIGIT_W-1:0] key_digit;
  logic               turn_clockwise;

  modport source (output valid, op, key_digit, turn_clockwise, input ready);
  modport sink   (input valid, op, key_digit, turn_clockwise, output ready);
endinterface

interface kpss_result_if import kpss_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [DUTY_W-1:0]   duty_clockwise;
  logic [DUTY_W-1:0]   duty_counterclockwise;
  logic [COUNT_W-1:0]  position;
  logic [COUNT_W-1:0]  reference;
  logic [STATUS_W-1:0] entry_status;

  modport source (output valid, duty_clockwise, duty_counterclockwise, position, reference,
                  entry_status, input ready);
  modport sink   (input valid, duty_clockwise, duty_counterclockwise, position, reference,
                  entry_status, output ready);
endinterface

/* rtl/kpss_front.sv */
// Front end: accepts event items, decodes the op into a one-hot kind and
// holds them in a short queue for the back end. Depends on kpss_pkg.
module kpss_front import kpss_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  kpss_item_if.sink    item_i,
  input  logic         pop_i,
  output queue_head_t  head_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  queue_item_t          slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]     count_q, count_d;
  queue_item_t          incoming;
  logic                 push, pop;

  always_comb begin
    unique case (op_e'(item_i.op))
      OP_DIGIT:   incoming.kind = KIND_DIGIT;
      OP_ENTER:   incoming.kind = KIND_ENTER;
      OP_ENCODER: incoming.kind = KIND_ENCODER;
      OP_TICK:    incoming.kind = KIND_TICK;
    endcase
    incoming.digit = item_i.key_digit;
    incoming.cw    = item_i.turn_clockwise;
  end

  assign item_i.ready = (count_q != CNT_W'(QUEUE_DEPTH));
  assign push         = item_i.valid && item_i.ready;
  assign pop          = pop_i && (count_q != '0);

  assign head_o.valid = (count_q != '0);
  assign head_o.item  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= incoming;
    end
  end

endmodule

/* rtl/kpss_back.sv */
// Back end: holds the servo state and configuration, carries out one queued
// item at a time and presents the result in an output register. Depends on kpss_pkg.
module kpss_back import kpss_pkg::*; #(
  parameter int unsigned POSITION_COUNTS = 160,
  parameter int unsigned ANGLE_MAX       = 360,
  parameter int unsigned PWM_MAX         = 1023
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cfg_write_t    cfg_i,
  input  queue_head_t   head_i,
  output logic          pop_o,
  kpss_result_if.source result_o
);

  localparam int unsigned CAP = (PWM_MAX > DUTY_LIMIT) ? DUTY_LIMIT : PWM_MAX;
  localparam logic [DUTY_W-1:0]  CAP_V = DUTY_W'(CAP);
  localparam logic [COUNT_W-1:0] PC_V  = COUNT_W'(POSITION_COUNTS);
  localparam logic [ANGLE_W-1:0] AM_V  = ANGLE_W'(ANGLE_MAX);
  localparam logic [DIV_W-1:0]   DIV_POS   = DIV_W'(POSITION_COUNTS);
  localparam logic [DIV_W-1:0]   DIV_ANGLE = DIV_W'(ANGLE_MAX);
  localparam logic [RECIP_W-1:0] RECIP_POS   = RECIP_W'((64'd1 << RECIP_SHIFT) / POSITION_COUNTS);
  localparam logic [RECIP_W-1:0] RECIP_ANGLE = RECIP_W'((64'd1 << RECIP_SHIFT) / ANGLE_MAX);
  localparam int unsigned FULL_W = NUM_W + RECIP_W;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_EXEC  = 6'b000010,
    ST_SCALE = 6'b000100,
    ST_RECIP = 6'b001000,
    ST_FIX   = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  state_e                 state_q, state_d;
  queue_item_t            item_q, item_d;

  logic [GAIN_W-1:0]      gain_q;
  logic [DEADBAND_W-1:0]  deadband_q;
  logic [DUTY_W-1:0]      min_duty_q;

  logic [DCOUNT_W-1:0]    digit_count_q, digit_count_d;
  logic [DIGIT_W-1:0]     digits_q [DIGIT_SLOTS];
  logic                   digit_we;
  logic [COUNT_W-1:0]     target_q, target_d;
  logic [COUNT_W-1:0]     encoder_q, encoder_d;
  logic [DUTY_W-1:0]      duty_cw_q, duty_cw_d;
  logic [DUTY_W-1:0]      duty_ccw_q, duty_ccw_d;
  entry_status_e          status_q, status_d;

  logic [ANGLE_W-1:0]     angle_q, angle_d;
  logic [MAG_W-1:0]       mag_q, mag_d;
  logic                   neg_q, neg_d;
  logic [PROD_W-1:0]      prod_q, prod_d;
  logic [NUM_W-1:0]       num_q, num_d;
  logic [NUM_W-1:0]       quot_q, quot_d;

  logic                   out_valid_q, out_valid_d;
  logic [DUTY_W-1:0]      out_cw_q, out_ccw_q;
  logic [COUNT_W-1:0]     out_pos_q, out_ref_q;
  entry_status_e          out_status_q;

  logic                   out_free, load_out, is_tick;
  logic                   err_neg;
  logic [COUNT_W-1:0]     err;
  logic [ANGLE_W-1:0]     angle;
  logic [DUTY_W-1:0]      span;
  logic [NUM_W-1:0]       num;
  logic [RECIP_W-1:0]     recip;
  logic [FULL_W-1:0]      full;
  logic [DIV_W-1:0]       divisor;
  logic [NUM_W-1:0]       back_prod, rem, quot_fix;
  logic [NUM_W:0]         duty_sum;
  logic [DUTY_W-1:0]      duty;

  // Datapath terms for the enter and tick paths.
  assign is_tick  = (item_q.kind == KIND_TICK);
  assign err_neg  = target_q < encoder_q;
  assign err      = err_neg ? encoder_q - target_q : target_q - encoder_q;
  assign angle    = ANGLE_W'(digits_q[0]) * ANGLE_W'(100)
                  + ANGLE_W'(digits_q[1]) * ANGLE_W'(10)
                  + ANGLE_W'(digits_q[2]);
  assign span     = (min_duty_q >= CAP_V) ? '0 : CAP_V - min_duty_q;

  // Constant division as a reciprocal multiply that may fall short by one,
  // put right in the following cycle.
  assign num      = is_tick ? prod_q[PROD_W-1:FRAC_W] : NUM_W'(prod_q);
  assign recip    = is_tick ? RECIP_POS : RECIP_ANGLE;
  assign full     = FULL_W'(num) * FULL_W'(recip);
  assign divisor  = is_tick ? DIV_POS : DIV_ANGLE;
  assign back_prod = NUM_W'(quot_q) * NUM_W'(divisor);
  assign rem      = num_q - back_prod;
  assign quot_fix = (rem >= NUM_W'(divisor)) ? quot_q + 1'b1 : quot_q;
  assign duty_sum = (NUM_W + 1)'(min_duty_q) + (NUM_W + 1)'(quot_fix);
  assign duty     = ((min_duty_q >= CAP_V) || (duty_sum > (NUM_W + 1)'(CAP)))
                  ? CAP_V : duty_sum[DUTY_W-1:0];

  assign out_free = !out_valid_q || result_o.ready;
  assign load_out = (state_q == ST_DONE) && out_free;
  assign pop_o    = head_i.valid && ((state_q == ST_IDLE) || load_out);

  always_comb begin
    state_d       = state_q;
    item_d        = item_q;
    digit_count_d = digit_count_q;
    digit_we      = 1'b0;
    target_d      = target_q;
    encoder_d     = encoder_q;
    duty_cw_d     = duty_cw_q;
    duty_ccw_d    = duty_ccw_q;
    status_d      = status_q;
    angle_d       = angle_q;
    mag_d         = mag_q;
    neg_d         = neg_q;
    prod_d        = prod_q;
    num_d         = num_q;
    quot_d        = quot_q;

    unique case (state_q)
      ST_IDLE: begin
        if (head_i.valid) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_DONE;
        unique case (item_q.kind)
          KIND_DIGIT: begin
            if (digit_count_q < DCOUNT_W'(DIGIT_SLOTS)) begin
              digit_we      = 1'b1;
              digit_count_d = digit_count_q + 1'b1;
            end
          end
          KIND_ENTER: begin
            // An enter before all three digits are held does nothing.
            if (digit_count_q >= DCOUNT_W'(DIGIT_SLOTS)) begin
              angle_d = angle;
              state_d = ST_SCALE;
            end
          end
          KIND_ENCODER: begin
            if (item_q.cw) begin
              encoder_d = (encoder_q >= PC_V) ? '0 : encoder_q + 1'b1;
            end else begin
              encoder_d = (encoder_q == '0) ? PC_V : encoder_q - 1'b1;
            end
          end
          KIND_TICK: begin
            neg_d   = err_neg;
            mag_d   = MAG_W'(gain_q) * MAG_W'(err);
            state_d = ST_SCALE;
          end
          default: begin
          end
        endcase
      end
      ST_SCALE: begin
        if (is_tick) begin
          if (mag_q <= MAG_W'({deadband_q, FRAC_W'(0)})) begin
            duty_cw_d  = '0;
            duty_ccw_d = '0;
            state_d    = ST_DONE;
          end else begin
            prod_d  = PROD_W'(mag_q) * PROD_W'(span);
            state_d = ST_RECIP;
          end
        end else begin
          digit_count_d = '0;
          if (angle_q > AM_V) begin
            status_d = ENTRY_REJECTED;
            state_d  = ST_DONE;
          end else begin
            prod_d  = PROD_W'(angle_q) * PROD_W'(PC_V);
            state_d = ST_RECIP;
          end
        end
      end
      ST_RECIP: begin
        num_d   = num;
        quot_d  = full[RECIP_SHIFT +: NUM_W];
        state_d = ST_FIX;
      end
      ST_FIX: begin
        state_d = ST_DONE;
        if (is_tick) begin
          duty_cw_d  = neg_q ? '0 : duty;
          duty_ccw_d = neg_q ? duty : '0;
        end else begin
          target_d = quot_fix[COUNT_W-1:0];
          status_d = ENTRY_ACCEPTED;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_d = head_i.valid ? ST_EXEC : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // Every new item starts with no entry status.
    if (pop_o) begin
      item_d   = head_i.item;
      status_d = ENTRY_NONE;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      gain_q        <= GAIN_W'(256);
      deadband_q    <= '0;
      min_duty_q    <= DUTY_W'(25);
      digit_count_q <= '0;
      target_q      <= TARGET_RESET;
      encoder_q     <= '0;
      duty_cw_q     <= '0;
      duty_ccw_q    <= '0;
      status_q      <= ENTRY_NONE;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      digit_count_q <= digit_count_d;
      target_q      <= target_d;
      encoder_q     <= encoder_d;
      duty_cw_q     <= duty_cw_d;
      duty_ccw_q    <= duty_ccw_d;
      status_q      <= status_d;
      out_valid_q   <= out_valid_d;
      if (cfg_i.we) begin
        unique case (cfg_index_e'(cfg_i.index))
          CFG_GAIN:     gain_q     <= cfg_i.data[GAIN_W-1:0];
          CFG_DEADBAND: deadband_q <= cfg_i.data[DEADBAND_W-1:0];
          CFG_MIN_DUTY: min_duty_q <= cfg_i.data[DUTY_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    angle_q <= angle_d;
    mag_q   <= mag_d;
    neg_q   <= neg_d;
    prod_q  <= prod_d;
    num_q   <= num_d;
    quot_q  <= quot_d;
    if (digit_we) begin
      digits_q[digit_count_q] <= item_q.digit;
    end
    if (load_out) begin
      out_cw_q     <= duty_cw_q;
      out_ccw_q    <= duty_ccw_q;
      out_pos_q    <= encoder_q;
      out_ref_q    <= target_q;
      out_status_q <= status_q;
    end
  end

  assign result_o.valid                 = out_valid_q;
  assign result_o.duty_clockwise        = out_cw_q;
  assign result_o.duty_counterclockwise = out_ccw_q;
  assign result_o.position              = out_pos_q;
  assign result_o.reference             = out_ref_q;
  assign result_o.entry_status          = out_status_q;

endmodule

/* rtl/keypad_setpoint_position_servo_unit.sv */
// Keypad setpoint position servo. Each item runs through the back end's sequencer:
// execute, done for a digit key, encoder edge or early enter; execute, scale, done
// for a tick inside the deadband or a rejected angle; execute, scale, reciprocal, fix,
// done for a driven tick or an accepted angle, the multiply and reciprocal-divide path.
// One item at a time; the next once a result is loaded. Reset clears the queue and
// output register and restores the servo state and registers at once; no clearing pass.
module keypad_setpoint_position_servo_unit import kpss_pkg::*; #(
  parameter int unsigned POSITION_COUNTS = 160,
  parameter int unsigned ANGLE_MAX       = 360,
  parameter int unsigned PWM_MAX         = 1023
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  kpss_item_if.sink              item_i,
  kpss_result_if.source          result_o
);

  cfg_write_t  cfg;
  queue_head_t head;
  logic        pop;

  assign cfg.we    = cfg_we_i;
  assign cfg.index = cfg_index_i;
  assign cfg.data  = cfg_wdata_i;

  kpss_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item_i),
    .pop_i  (pop),
    .head_o (head)
  );

  kpss_back #(
    .POSITION_COUNTS (POSITION_COUNTS),
    .ANGLE_MAX       (ANGLE_MAX),
    .PWM_MAX         (PWM_MAX)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .head_i   (head),
    .pop_o    (pop),
    .result_o (result_o)
  );

endmodule
